@@ sv/dtip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dtip_pkg;

	localparam int unsigned AccW = 34;
	localparam int unsigned CntW = 4;

	localparam logic [AccW-1:0] POS_LIMIT = 34'd2147483647;
	localparam logic [AccW-1:0] NEG_LIMIT = 34'd2147483648;
	localparam logic [31:0] POS_VALUE = 32'h7fff_ffff;
	localparam logic [31:0] NEG_VALUE = 32'h8000_0000;

	localparam logic [CntW-1:0] MAX_DIGITS = 4'd12;
	localparam logic [CntW-1:0] SAT_DIGITS = 4'd11;
	localparam logic [CntW-1:0] ACC_DIGITS = 4'd10;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7a;

	typedef struct packed {
		logic       is_lower;
		logic       is_digit;
		logic       is_plus;
		logic       is_minus;
		logic       is_space;
		logic       is_dot;
		logic       is_nul;
		logic       is_zero;
		logic [3:0] dval;
		logic       last;
	} cls_t;

endpackage

`default_nettype wire

@@ sv/dtip_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtip_front
	import dtip_pkg::*;
(
	input  wire logic [7:0] ch,
	input  wire logic       last,
	output cls_t            cls
);

	always_comb begin
		cls.is_lower = (ch >= CH_LOW_A) && (ch <= CH_LOW_Z);
		cls.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		cls.is_plus  = (ch == CH_PLUS);
		cls.is_minus = (ch == CH_MINUS);
		cls.is_space = (ch == CH_SPACE);
		cls.is_dot   = (ch == CH_DOT);
		cls.is_nul   = (ch == CH_NUL);
		cls.is_zero  = (ch == CH_ZERO);
		cls.dval     = ch[3:0];
		cls.last     = last;
	end

endmodule

`default_nettype wire

@@ sv/dtip_cls_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtip_cls_queue
	import dtip_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cls_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output logic      rd_valid,
	output cls_t      rd_data
);

	cls_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/dtip_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtip_back
	import dtip_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire cls_t         in_cls,
	output logic              in_take,
	output logic              empty,
	input  wire logic         pop,
	output logic signed [31:0] value
);

	logic            finished_q;
	logic            at_start_q;
	logic            neg_q;
	logic            sign_q;
	logic            lz_q;
	logic [CntW-1:0] dc_q;
	logic [AccW-1:0] acc_q;

	logic            f_n;
	logic            as_n;
	logic            neg_n;
	logic            sign_n;
	logic            lz_n;
	logic [CntW-1:0] dc_n;
	logic [AccW-1:0] acc_n;

	logic            valid_s1;
	logic            neg_s1;
	logic [CntW-1:0] dc_s1;
	logic [AccW-1:0] acc_s1;

	logic [31:0]     res_mem_q [2];
	logic            res_wr_q;
	logic            res_rd_q;
	logic [1:0]      res_cnt_q;
	logic            res_full;
	logic            res_push;
	logic            res_pop;
	logic [31:0]     final_val;

	assign res_full = (res_cnt_q == 2'd2);
	assign res_push = valid_s1 && !res_full;
	assign res_pop  = pop && !empty;
	assign empty    = (res_cnt_q == 2'd0);
	assign value    = res_mem_q[res_rd_q];
	assign in_take  = in_valid && (!in_cls.last || !valid_s1 || res_push);

	// per-byte rule chain
	always_comb begin
		logic stop;
		logic begun;
		f_n    = finished_q;
		as_n   = at_start_q;
		neg_n  = neg_q;
		sign_n = sign_q;
		lz_n   = lz_q;
		dc_n   = dc_q;
		acc_n  = acc_q;
		stop   = finished_q;
		begun  = sign_q || lz_q || (dc_q != '0);
		if (!stop && at_start_q) begin
			as_n = 1'b0;
			if (in_cls.is_lower || in_cls.is_dot) begin
				f_n   = 1'b1;
				acc_n = '0;
				dc_n  = '0;
				stop  = 1'b1;
			end
		end
		if (!stop && (in_cls.is_nul || dc_q >= MAX_DIGITS)) begin
			f_n  = 1'b1;
			stop = 1'b1;
		end
		if (!stop && dc_q == '0 && in_cls.is_lower) begin
			f_n   = 1'b1;
			acc_n = '0;
			dc_n  = '0;
			stop  = 1'b1;
		end
		if (!stop && dc_q != '0 && (in_cls.is_plus || in_cls.is_minus ||
				in_cls.is_space || in_cls.is_lower)) begin
			f_n  = 1'b1;
			stop = 1'b1;
		end
		if (!stop && begun && (in_cls.is_plus || in_cls.is_minus)) begin
			f_n   = 1'b1;
			acc_n = '0;
			dc_n  = '0;
			stop  = 1'b1;
		end
		if (!stop && begun && (in_cls.is_lower || in_cls.is_dot || in_cls.is_space)) begin
			f_n  = 1'b1;
			stop = 1'b1;
		end
		if (!stop) begin
			priority if (in_cls.is_minus) begin
				neg_n  = 1'b1;
				sign_n = 1'b1;
			end else if (in_cls.is_plus) begin
				neg_n  = 1'b0;
				sign_n = 1'b1;
			end else if (dc_q == '0 && in_cls.is_zero) begin
				lz_n = 1'b1;
			end else if (in_cls.is_digit) begin
				if (dc_q < ACC_DIGITS) begin
					acc_n = (acc_q << 3) + (acc_q << 1) + {{(AccW-4){1'b0}}, in_cls.dval};
				end
				dc_n = dc_q + 4'd1;
				if (dc_n >= MAX_DIGITS) begin
					f_n = 1'b1;
				end
			end else begin
				f_n = finished_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q <= 1'b0;
			at_start_q <= 1'b1;
			neg_q      <= 1'b0;
			sign_q     <= 1'b0;
			lz_q       <= 1'b0;
			dc_q       <= '0;
			acc_q      <= '0;
		end else if (in_take) begin
			if (in_cls.last) begin
				finished_q <= 1'b0;
				at_start_q <= 1'b1;
				neg_q      <= 1'b0;
				sign_q     <= 1'b0;
				lz_q       <= 1'b0;
				dc_q       <= '0;
				acc_q      <= '0;
			end else begin
				finished_q <= f_n;
				at_start_q <= as_n;
				neg_q      <= neg_n;
				sign_q     <= sign_n;
				lz_q       <= lz_n;
				dc_q       <= dc_n;
				acc_q      <= acc_n;
			end
		end
	end

	// end of string snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take && in_cls.last) begin
			valid_s1 <= 1'b1;
		end else if (res_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && in_cls.last) begin
			neg_s1 <= neg_n;
			dc_s1  <= dc_n;
			acc_s1 <= acc_n;
		end
	end

	// saturation and sign
	always_comb begin
		priority if (dc_s1 >= SAT_DIGITS) begin
			final_val = neg_s1 ? NEG_VALUE : POS_VALUE;
		end else if (!neg_s1 && acc_s1 > POS_LIMIT) begin
			final_val = POS_VALUE;
		end else if (neg_s1 && acc_s1 > NEG_LIMIT) begin
			final_val = NEG_VALUE;
		end else if (neg_s1) begin
			final_val = 32'd0 - acc_s1[31:0];
		end else begin
			final_val = acc_s1[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wr_q] <= final_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= !res_rd_q;
			end
			unique case ({res_push, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/decimal_text_to_int32_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   signals               transaction when
// byte in   ch, last / push, full push && !full
// result    value / empty, pop    pop && !empty
//
// one byte per cycle unless a stalled result queue holds a last byte;
// results pass byte queue, rule stage, then saturation stage in turn
// arst_n clears both queues and the per-string state
// a stalled result queue backs up into the byte queue only on a last byte
// two-entry queues on both sides, so full and empty are registered

module decimal_text_to_int32_parser
	import dtip_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [7:0]   ch,
	input  wire logic         last,
	input  wire logic         push,
	output logic              full,
	output logic signed [31:0] value,
	output logic              empty,
	input  wire logic         pop
);

	cls_t front_cls;
	cls_t q_cls;
	logic q_valid;
	logic q_take;

	dtip_front u_front (
		.ch   (ch),
		.last (last),
		.cls  (front_cls)
	);

	dtip_cls_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (front_cls),
		.full     (full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_cls)
	);

	dtip_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_cls   (q_cls),
		.in_take  (q_take),
		.empty    (empty),
		.pop      (pop),
		.value    (value)
	);

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import dtip_pkg::*;

	logic clk;
	logic arst_n;
	logic [7:0] ch;
	logic last;
	logic push;
	logic full;
	logic signed [31:0] value;
	logic empty;
	logic pop;

	// parser state as seen by the predictor
	logic p_done;
	logic p_fresh;
	logic p_neg;
	logic p_sign;
	logic p_lzero;
	logic [3:0] p_count;
	logic [33:0] p_mag;

	logic [31:0] pending_values[$];
	int errors = 0;
	int bytes_sent = 0;
	int long_hold = 0;
	bit idling = 0;

	decimal_text_to_int32_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.ch(ch),
		.last(last),
		.push(push),
		.full(full),
		.value(value),
		.empty(empty),
		.pop(pop)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic void clear_parse();
		p_done = 1'b0;
		p_fresh = 1'b1;
		p_neg = 1'b0;
		p_sign = 1'b0;
		p_lzero = 1'b0;
		p_count = '0;
		p_mag = '0;
	endfunction

	function automatic void zero_parse();
		p_done = 1'b1;
		p_mag = '0;
		p_count = '0;
	endfunction

	function automatic void parse_byte(input logic [7:0] c);
		logic lower;
		logic digit;
		logic sgn;
		logic begun;
		lower = c >= CH_LOW_A && c <= CH_LOW_Z;
		digit = c >= CH_ZERO && c <= CH_NINE;
		sgn = c == CH_PLUS || c == CH_MINUS;
		if (p_done)
			return;
		if (p_fresh) begin
			p_fresh = 1'b0;
			if (lower || c == CH_DOT) begin
				zero_parse();
				return;
			end
		end
		if (c == CH_NUL || p_count >= MAX_DIGITS) begin
			p_done = 1'b1;
			return;
		end
		if (p_count == 0 && lower) begin
			zero_parse();
			return;
		end
		if (p_count != 0 && (sgn || c == CH_SPACE || lower)) begin
			p_done = 1'b1;
			return;
		end
		begun = p_sign || p_lzero || p_count != 0;
		if (begun && sgn) begin
			zero_parse();
			return;
		end
		if (begun && (lower || c == CH_DOT || c == CH_SPACE)) begin
			p_done = 1'b1;
			return;
		end
		if (c == CH_MINUS) begin
			p_neg = 1'b1;
			p_sign = 1'b1;
		end else if (c == CH_PLUS) begin
			p_neg = 1'b0;
			p_sign = 1'b1;
		end else if (p_count == 0 && c == CH_ZERO) begin
			p_lzero = 1'b1;
		end else if (digit) begin
			if (p_count < ACC_DIGITS)
				p_mag = p_mag * 10 + (c - CH_ZERO);
			p_count = p_count + 1'b1;
			if (p_count >= MAX_DIGITS)
				p_done = 1'b1;
		end
	endfunction

	function automatic logic [31:0] parsed_value();
		if (p_count >= SAT_DIGITS)
			return p_neg ? NEG_VALUE : POS_VALUE;
		if (!p_neg && p_mag > POS_LIMIT)
			return POS_VALUE;
		if (p_neg && p_mag > NEG_LIMIT)
			return NEG_VALUE;
		if (p_neg)
			return -p_mag[31:0];
		return p_mag[31:0];
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic l);
		push <= 1'b1;
		ch <= c;
		last <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_sent++;
		parse_byte(c);
		if (l) begin
			pending_values.push_back(parsed_value());
			clear_parse();
		end
		if (idling && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14))
				@(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic send_random_string();
		logic [7:0] txt[$];
		string lim;
		int n;
		lim = "21474836";
		if ($urandom_range(0, 4) == 0) begin
			// noise
			repeat ($urandom_range(1, 6))
				txt.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) begin
				case ($urandom_range(0, 2))
				0: txt.push_back(CH_SPACE);
				1: txt.push_back(8'($urandom_range(8'h41, 8'h5a)));
				default: txt.push_back(8'($urandom_range(8'h80, 8'hff)));
				endcase
			end
			case ($urandom_range(0, 3))
			0: txt.push_back(CH_MINUS);
			1: txt.push_back(CH_PLUS);
			default: ;
			endcase
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					txt.push_back(CH_ZERO);
			case ($urandom_range(0, 5))
			0: n = $urandom_range(1, 3);
			1, 2: n = $urandom_range(4, 9);
			3: begin
				// close to the signed limits
				for (int i = 0; i < lim.len(); i++)
					txt.push_back(lim[i]);
				n = 2;
			end
			4: n = 10;
			default: n = $urandom_range(11, 13);
			endcase
			repeat (n)
				txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			case ($urandom_range(0, 7))
			0: ;
			1: txt.push_back(CH_SPACE);
			2: txt.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
			3: txt.push_back(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
			4: txt.push_back(CH_DOT);
			5: txt.push_back(CH_NUL);
			6: txt.push_back(8'($urandom_range(0, 255)));
			default: txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			endcase
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					txt.push_back(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < txt.size(); i++)
			send_byte(txt[i], i == txt.size() - 1);
	endtask

	task automatic test_directed();
		send_text("a");
		send_text(".");
		send_byte(8'hff, 1'b0);
		send_byte("7", 1'b1);
		send_byte(CH_MINUS, 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte("9", 1'b1);
		send_text("+-1");
		send_text(" -7x");
		// twelve digits saturate, the trailing digit is ignored
		send_text("-1234567890125");
	endtask

	task automatic test_random(input int count);
		int stop;
		stop = bytes_sent + count;
		while (bytes_sent < stop) begin
			if ($urandom_range(0, 15) == 0)
				idling = !idling;
			send_random_string();
		end
	endtask

	task automatic test_backpressure();
		idling = 1'b0;
		long_hold = 150;
		repeat (40)
			send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
	endtask

	task automatic test_streaming(input int count);
		int stop;
		idling = 1'b0;
		stop = bytes_sent + count;
		while (bytes_sent < stop)
			send_random_string();
	endtask

	// result side: pop with random stalls, check each transaction
	initial begin
		int stall_left;
		stall_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_values.size() == 0) begin
					$error("value: unexpected result %0d", value);
					errors++;
				end else begin
					if (value !== pending_values[0]) begin
						$error("value: expected %0d, actual %0d",
							$signed(pending_values[0]), value);
						errors++;
					end
					void'(pending_values.pop_front());
				end
			end
			if (long_hold > 0) begin
				pop <= 1'b0;
				long_hold--;
			end else if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		ch <= '0;
		last <= 1'b0;
		clear_parse();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		idling = 1'b1;
		test_random(650);
		test_backpressure();
		idling = 1'b1;
		test_random(150);
		test_streaming(100);
		push <= 1'b0;
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
